@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/qbc_pkg.sv @@
// Package for the quadratic Bezier extremum chop core.
// Default width constants. No dependencies.
`default_nettype none
package qbc_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 16;
endpackage
`default_nettype wire

@@ hw/rtl/qbc_if.sv @@
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
`default_nettype none
interface qbc_if #(
    parameter int W = 1
) (
    input wire logic clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/qbc_div_cell.sv @@
// One restoring-division cell: one quotient bit per stage, carries the curve.
// Depends on nothing but its ports.
`default_nettype none
module qbc_div_cell #(
    parameter int DW = 34,
    parameter int TW = 16,
    parameter int PW = 200
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [DW-1:0] den_in,
    input  wire logic [TW-1:0] q_in,
    input  wire logic [PW-1:0] pay_in,
    output logic               vld_out,
    output logic [DW-1:0]      rem_out,
    output logic [DW-1:0]      den_out,
    output logic [TW-1:0]      q_out,
    output logic [PW-1:0]      pay_out
);
    logic [DW:0] sh;
    logic        ge;
    logic        vld_reg;
    logic [DW-1:0] rem_reg, den_reg;
    logic [TW-1:0] q_reg;
    logic [PW-1:0] pay_reg;

    always_comb
    begin
        sh = {rem_in, 1'b0};
        ge = (sh >= {1'b0, den_in});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? DW'(sh - {1'b0, den_in}) : sh[DW-1:0];
            den_reg <= den_in;
            q_reg   <= {q_in[TW-2:0], ge};
            pay_reg <= pay_in;
        end
    end

    assign vld_out = vld_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;
    assign pay_out = pay_reg;
endmodule
`default_nettype wire

@@ hw/rtl/qbc_lerp.sv @@
// Floor interpolation p + floor((q-p)*t / 2^TW), one registered stage.
// Depends on nothing but its ports.
`default_nettype none
module qbc_lerp #(
    parameter int CW = 32,
    parameter int TW = 16
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [CW-1:0] p,
    input  wire logic signed [CW-1:0] q,
    input  wire logic        [TW-1:0] t,
    output logic signed      [CW-1:0] r
);
    logic signed [CW:0]      d;
    logic signed [CW+TW+1:0] prod;
    logic signed [CW-1:0]    r_reg;

    always_comb
    begin
        d    = (CW+1)'(q) - (CW+1)'(p);
        prod = (CW+TW+2)'(d) * $signed({2'b00, t});
    end

    // arithmetic shift floors; result lies between p and q so it fits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= CW'((CW+1)'(p) + (CW+1)'(prod >>> TW));
        end
    end

    assign r = r_reg;
endmodule
`default_nettype wire

@@ hw/rtl/quad_bezier_extremum_chop_core.sv @@
// Top level of the quadratic Bezier extremum chop core.
// Depends on qbc_pkg, qbc_if, qbc_div_cell, qbc_lerp, assert_macros.svh.
//
// channel | dir | payload
// in_ch   | in  | axis_sel, p0..p2 x/y
// out_ch  | out | split_done, out0..out4 x/y
//
// One item per cycle while the output is not stalled; the pipeline is a setup stage, the chain of
// divider cells (one quotient bit each) and two lerp stages.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears only valid bits.
`default_nettype none
`include "assert_macros.svh"
module quad_bezier_extremum_chop_core #(
    parameter int COORD_WIDTH = qbc_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = qbc_pkg::T_FRAC_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    qbc_if.sink      in_ch,
    qbc_if.source    out_ch
);
    localparam int CW = COORD_WIDTH;
    localparam int TW = T_FRAC_BITS;
    localparam int DW = CW + 3;
    localparam int PW = 6*CW + 3;
    localparam int NS = TW + 1;

    logic en;
    logic out_vld_reg;
    assign en = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = en;

    // input unpack
    logic                 axis;
    logic signed [CW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, a, b, c;
    assign {axis, p0x, p0y, p1x, p1y, p2x, p2y} = in_ch.data;

    logic signed [CW+1:0] ab, bc, dd, nn, dn;
    logic notmono, try_div, bsel;
    logic signed [CW-1:0] bsnap;

    always_comb
    begin
        a  = axis ? p0y : p0x;
        b  = axis ? p1y : p1x;
        c  = axis ? p2y : p2x;
        ab = (CW+2)'(a) - (CW+2)'(b);
        bc = (CW+2)'(b) - (CW+2)'(c);
        dd = ab - bc;
        notmono = (ab == '0) || (ab > 0 && bc < 0) || (ab < 0 && bc > 0);
        nn = ab[CW+1] ? -ab : ab;
        dn = ab[CW+1] ? -dd : dd;
        try_div = notmono && (dd != '0) && (dn > 0) && (nn > 0) && (nn < dn);
        bsel  = ((ab[CW+1] ? -ab : ab) < (bc[CW+1] ? -bc : bc));
        bsnap = bsel ? a : c;
    end

    // payload: try_div, axis, notmono and the unsnapped points; snapped control values ride separately
    logic [PW-1:0] pay0;
    logic signed [CW-1:0] sx, sy;
    always_comb
    begin
        sx = (notmono && !axis) ? bsnap : p1x;
        sy = (notmono && axis) ? bsnap : p1y;
    end
    assign pay0 = {try_div, axis, notmono, p0x, p0y, p1x, p1y, p2x, p2y};

    logic          vld [NS+1];
    logic [DW-1:0] rem [NS+1];
    logic [DW-1:0] den [NS+1];
    logic [TW-1:0] qq  [NS+1];
    logic [PW-1:0] pay [NS+1];
    logic signed [CW-1:0] snx_reg [NS], sny_reg [NS];

    assign vld[0] = in_ch.valid;
    assign rem[0] = DW'(nn);
    assign den[0] = try_div ? DW'(dn) : DW'(1);
    assign qq[0]  = '0;
    assign pay[0] = pay0;

    // snapped control coordinates ride alongside the chain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            snx_reg[0] <= sx;
            sny_reg[0] <= sy;
            for (int k = 1; k < NS; k++)
            begin
                snx_reg[k] <= snx_reg[k-1];
                sny_reg[k] <= sny_reg[k-1];
            end
        end
    end

    // first cell is a pass stage (register setup), the rest produce bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld[1] <= 1'b0;
        end
        else if (en)
        begin
            vld[1] <= vld[0];
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem[1] <= rem[0];
            den[1] <= den[0];
            qq[1]  <= qq[0];
            pay[1] <= pay[0];
        end
    end

    for (genvar g = 1; g < NS; g++)
    begin : g_div
        qbc_div_cell #(.DW(DW), .TW(TW), .PW(PW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vld_in(vld[g]), .rem_in(rem[g]), .den_in(den[g]),
            .q_in(qq[g]), .pay_in(pay[g]),
            .vld_out(vld[g+1]), .rem_out(rem[g+1]), .den_out(den[g+1]),
            .q_out(qq[g+1]), .pay_out(pay[g+1])
        );
    end

    // end of divider chain
    logic [TW-1:0] tq;
    logic          split_c, axis_c, nm_c;
    logic signed [CW-1:0] q0x, q0y, q1x, q1y, q2x, q2y;
    assign tq = qq[NS];
    assign {split_c, axis_c, nm_c, q0x, q0y, q1x, q1y, q2x, q2y} = pay[NS];
    logic split_now;
    assign split_now = split_c && (tq != '0);

    // lerp stage 1
    logic signed [CW-1:0] r1x, r1y, r3x, r3y;
    qbc_lerp #(.CW(CW), .TW(TW)) u_l1x (.clk(clk), .en(en), .p(q0x), .q(q1x), .t(tq), .r(r1x));
    qbc_lerp #(.CW(CW), .TW(TW)) u_l1y (.clk(clk), .en(en), .p(q0y), .q(q1y), .t(tq), .r(r1y));
    qbc_lerp #(.CW(CW), .TW(TW)) u_l3x (.clk(clk), .en(en), .p(q1x), .q(q2x), .t(tq), .r(r3x));
    qbc_lerp #(.CW(CW), .TW(TW)) u_l3y (.clk(clk), .en(en), .p(q1y), .q(q2y), .t(tq), .r(r3y));

    logic                 s1_vld_reg, s1_split_reg, s1_axis_reg;
    logic [TW-1:0]        s1_t_reg;
    logic signed [CW-1:0] s1_p0x_reg, s1_p0y_reg, s1_p1x_reg, s1_p1y_reg;
    logic signed [CW-1:0] s1_p2x_reg, s1_p2y_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= vld[NS];
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_split_reg <= split_now;
            s1_axis_reg  <= axis_c;
            s1_t_reg     <= tq;
            s1_p0x_reg   <= q0x;
            s1_p0y_reg   <= q0y;
            s1_p1x_reg   <= (split_now || !nm_c) ? q1x : snx_reg[NS-1];
            s1_p1y_reg   <= (split_now || !nm_c) ? q1y : sny_reg[NS-1];
            s1_p2x_reg   <= q2x;
            s1_p2y_reg   <= q2y;
        end
    end

    // lerp stage 2
    logic signed [CW-1:0] r2x, r2y;
    qbc_lerp #(.CW(CW), .TW(TW)) u_l2x (.clk(clk), .en(en), .p(r1x), .q(r3x),
                                        .t(s1_t_reg), .r(r2x));
    qbc_lerp #(.CW(CW), .TW(TW)) u_l2y (.clk(clk), .en(en), .p(r1y), .q(r3y),
                                        .t(s1_t_reg), .r(r2y));

    logic                 s2_split_reg, s2_axis_reg;
    logic signed [CW-1:0] s2_p0x_reg, s2_p0y_reg, s2_p1x_reg, s2_p1y_reg;
    logic signed [CW-1:0] s2_p2x_reg, s2_p2y_reg, s2_r1x_reg, s2_r1y_reg;
    logic signed [CW-1:0] s2_r3x_reg, s2_r3y_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= s1_vld_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_split_reg <= s1_split_reg;
            s2_axis_reg  <= s1_axis_reg;
            s2_p0x_reg   <= s1_p0x_reg;
            s2_p0y_reg   <= s1_p0y_reg;
            s2_p1x_reg   <= s1_p1x_reg;
            s2_p1y_reg   <= s1_p1y_reg;
            s2_p2x_reg   <= s1_p2x_reg;
            s2_p2y_reg   <= s1_p2y_reg;
            s2_r1x_reg   <= r1x;
            s2_r1y_reg   <= r1y;
            s2_r3x_reg   <= r3x;
            s2_r3y_reg   <= r3y;
        end
    end

    logic signed [CW-1:0] o0x, o0y, o1x, o1y, o2x, o2y, o3x, o3y, o4x, o4y;
    always_comb
    begin
        o0x = s2_p0x_reg;
        o0y = s2_p0y_reg;
        if (s2_split_reg)
        begin
            o2x = r2x;
            o2y = r2y;
            o1x = s2_axis_reg ? s2_r1x_reg : r2x;
            o1y = s2_axis_reg ? r2y : s2_r1y_reg;
            o3x = s2_axis_reg ? s2_r3x_reg : r2x;
            o3y = s2_axis_reg ? r2y : s2_r3y_reg;
            o4x = s2_p2x_reg;
            o4y = s2_p2y_reg;
        end
        else
        begin
            o1x = s2_p1x_reg;
            o1y = s2_p1y_reg;
            o2x = s2_p2x_reg;
            o2y = s2_p2y_reg;
            o3x = '0;
            o3y = '0;
            o4x = '0;
            o4y = '0;
        end
    end

    assign out_ch.valid = out_vld_reg;
    assign out_ch.data  = {s2_split_reg, o0x, o0y, o1x, o1y, o2x, o2y,
                           o3x, o3y, o4x, o4y};

    `ASSERT_IMPL(a_stall_ready, clk, rst_n, out_vld_reg && !out_ch.ready, !in_ch.ready)
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, out_vld_reg && !out_ch.ready, out_vld_reg)
    `ASSERT_IMPL(a_zero_tail, clk, rst_n, out_vld_reg && !s2_split_reg, o3x == '0 && o4y == '0)
endmodule
`default_nettype wire
